[rtl/utf8e_pkg.sv]
// ----------------------------------------------------------------------------
// utf8e_pkg
// Shared types and constants for the UTF-8 encoder with a byte budget: the
// queue entry handed from the classifying front end to the byte serializer.
// ----------------------------------------------------------------------------
package utf8e_pkg;

   // Width of one encoded byte and of the reported string length.
   localparam int BYTE_W = 8;
   localparam int TLEN_W = 16;

   // Most bytes one code point can expand to, and the index width over them.
   localparam int MAX_BYTES = 4;
   localparam int BIDX_W    = 2;

   // Entries in the queue between front and back end (a power of two).
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Width of the configuration register index.
   localparam int CSR_IDX_W = 2;

   // One unit of work for the back end: either 1 to 4 encoded bytes, or the
   // single length result of a terminator.
   typedef struct packed {
      logic                                   is_length;
      logic [BIDX_W-1:0]                      last_idx;
      logic [MAX_BYTES-1:0][BYTE_W-1:0]       bytes;
      logic [TLEN_W-1:0]                      total_length;
   } entry_type;

endpackage

[rtl/utf8e_front.sv]
// ----------------------------------------------------------------------------
// utf8e_front
// Front end: classifies each accepted code point, encodes it, applies the
// byte budget and keeps the running count, then queues the work for output.
// ----------------------------------------------------------------------------
module utf8e_front #(
   parameter int LEN_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [30:0]                req_code_point,
   input  logic                       limit_enable,
   input  logic [utf8e_pkg::TLEN_W-1:0] byte_limit,
   output logic                       push,
   output utf8e_pkg::entry_type       push_data
);

   // Range bounds of the four encoding lengths.
   localparam logic [30:0] BOUND_1 = 31'h0000080;
   localparam logic [30:0] BOUND_2 = 31'h0000800;
   localparam logic [30:0] BOUND_3 = 31'h0010000;
   localparam logic [30:0] BOUND_4 = 31'h0110000;

   // Lead byte prefixes and the continuation byte prefix.
   localparam logic [2:0] LEAD_2 = 3'b110;
   localparam logic [3:0] LEAD_3 = 4'b1110;
   localparam logic [4:0] LEAD_4 = 5'b11110;
   localparam logic [1:0] CONT   = 2'b10;

   localparam int SUM_W = LEN_BITS + 1;
   localparam int CMP_W = LEN_BITS + utf8e_pkg::TLEN_W + 1;

   logic [LEN_BITS-1:0] count_ff, count_in;
   logic                halted_ff, halted_in;

   logic                accept;
   logic                is_term;
   logic [2:0]          nbytes;
   logic [utf8e_pkg::MAX_BYTES-1:0][utf8e_pkg::BYTE_W-1:0] enc;
   logic [SUM_W-1:0]    sum;
   logic [CMP_W-1:0]    sum_ext;
   logic [CMP_W-1:0]    limit_ext;
   logic                over_budget;
   logic [LEN_BITS+utf8e_pkg::TLEN_W-1:0] count_wide;
   logic [LEN_BITS-1:0] count_sat;

   assign accept  = req_valid && !req_stall;
   assign is_term = (req_code_point == '0);

   // Encode the code point; zero bytes means it is out of range.
   always_comb begin
      enc = '0;
      priority if (req_code_point < BOUND_1) begin
         nbytes = 3'd1;
         enc[0] = req_code_point[7:0];
      end else if (req_code_point < BOUND_2) begin
         nbytes = 3'd2;
         enc[0] = {LEAD_2, req_code_point[10:6]};
         enc[1] = {CONT, req_code_point[5:0]};
      end else if (req_code_point < BOUND_3) begin
         nbytes = 3'd3;
         enc[0] = {LEAD_3, req_code_point[15:12]};
         enc[1] = {CONT, req_code_point[11:6]};
         enc[2] = {CONT, req_code_point[5:0]};
      end else if (req_code_point < BOUND_4) begin
         nbytes = 3'd4;
         enc[0] = {LEAD_4, req_code_point[20:18]};
         enc[1] = {CONT, req_code_point[17:12]};
         enc[2] = {CONT, req_code_point[11:6]};
         enc[3] = {CONT, req_code_point[5:0]};
      end else begin
         nbytes = 3'd0;
      end
   end

   // Budget test on the true sum; the stored count saturates.
   assign sum         = {1'b0, count_ff} + {{(SUM_W-3){1'b0}}, nbytes};
   assign sum_ext     = {{(CMP_W-SUM_W){1'b0}}, sum};
   assign limit_ext   = {{(CMP_W-utf8e_pkg::TLEN_W){1'b0}}, byte_limit};
   assign over_budget = limit_enable && (sum_ext > limit_ext);
   assign count_sat   = sum[LEN_BITS] ? {LEN_BITS{1'b1}} : sum[LEN_BITS-1:0];
   assign count_wide  = {{utf8e_pkg::TLEN_W{1'b0}}, count_ff};

   // Decide what the item leaves in the queue and in the string state.
   always_comb begin
      count_in  = count_ff;
      halted_in = halted_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (is_term) begin
            push                   = 1'b1;
            push_data.is_length    = 1'b1;
            push_data.total_length = count_wide[utf8e_pkg::TLEN_W-1:0];
            count_in               = '0;
            halted_in              = 1'b0;
         end else if (!halted_ff && (nbytes != 3'd0)) begin
            if (over_budget) begin
               halted_in = 1'b1;
            end else begin
               count_in           = count_sat;
               push               = 1'b1;
               push_data.last_idx = 2'(nbytes - 3'd1);
               push_data.bytes    = enc;
            end
         end
      end
   end

   // String state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         halted_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         halted_ff <= halted_in;
      end
   end

`ifndef SYNTHESIS
   // A halted string passes nothing but its terminator to the queue.
   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      halted_ff && accept && !is_term |-> !push)
      else $error("front: halted string produced a byte entry");
`endif

endmodule

[rtl/utf8e_fifo.sv]
// ----------------------------------------------------------------------------
// utf8e_fifo
// Short queue of work entries between the front end and the byte serializer,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module utf8e_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  utf8e_pkg::entry_type push_data,
   input  logic                 pop,
   output utf8e_pkg::entry_type head,
   output logic                 full,
   output logic                 empty
);

   utf8e_pkg::entry_type mem [utf8e_pkg::QUEUE_DEPTH];

   logic [utf8e_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utf8e_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utf8e_pkg::QPTR_W:0]   count_ff, count_in;

   assign full  = (count_ff == (utf8e_pkg::QPTR_W+1)'(utf8e_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // The front end never writes into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("fifo: push while full");

   // The back end never takes from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("fifo: pop while empty");
`endif

endmodule

[rtl/utf8e_back.sv]
// ----------------------------------------------------------------------------
// utf8e_back
// Back end: takes queued entries and, while rsp_stall is low, sends them out
// one result per cycle via an output register, marking each item's last.
// ----------------------------------------------------------------------------
module utf8e_back (
   input  logic                          clock,
   input  logic                          reset,
   input  utf8e_pkg::entry_type          head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [utf8e_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                          rsp_is_length,
   output logic [utf8e_pkg::TLEN_W-1:0]  rsp_total_length,
   output logic                          rsp_last
);

   utf8e_pkg::entry_type          cur_ff, cur_in;
   logic                          cur_valid_ff, cur_valid_in;
   logic [utf8e_pkg::BIDX_W-1:0]  idx_ff, idx_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [utf8e_pkg::BYTE_W-1:0]  rsp_out_byte_ff;
   logic                          rsp_is_length_ff;
   logic [utf8e_pkg::TLEN_W-1:0]  rsp_total_length_ff;
   logic                          rsp_last_ff;

   logic out_free;
   logic emit;
   logic at_last;
   logic done;

   // The output register can take a result when empty or being drained.
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = cur_valid_ff && out_free;
   assign at_last  = (idx_ff == cur_ff.last_idx);
   assign done     = emit && at_last;
   assign pop      = !empty && (!cur_valid_ff || done);

   // Walk through the bytes of the current entry.
   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (pop) begin
         cur_in       = head;
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 1'b1;
      end
      rsp_valid_in = emit ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Current entry and output payload.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rsp_out_byte_ff     <= cur_ff.bytes[idx_ff];
         rsp_is_length_ff    <= cur_ff.is_length;
         rsp_total_length_ff <= cur_ff.total_length;
         rsp_last_ff         <= at_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_out_byte_ff;
   assign rsp_is_length    = rsp_is_length_ff;
   assign rsp_total_length = rsp_total_length_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTHESIS
   // The byte index never runs past the entry's last byte.
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= cur_ff.last_idx)
      else $error("back: byte index past end of entry");

   // A length result is alone for its item and carries no byte.
   a_length_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_is_length_ff |-> rsp_last_ff && (rsp_out_byte_ff == '0))
      else $error("back: malformed length result");
`endif

endmodule

[rtl/utf8_encoder_with_byte_budget.sv]
// ----------------------------------------------------------------------------
// utf8_encoder_with_byte_budget
// Encodes a stream of code points to UTF-8 bytes under an optional per-string
// byte budget; a zero code point ends the string and reports its length.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Payload
//   req_     in         req_valid / req_stall   req_code_point
//   rsp_     out        rsp_valid / rsp_stall   rsp_out_byte, rsp_is_length,
//                                               rsp_total_length, rsp_last
//   csr_     in         csr_valid / csr_ready   csr_index, csr_data
//
// A code point is accepted every cycle while the four-entry queue has room.
// Each item gives 1 to 4 results for a character, 1 for a terminator and
// none for a dropped one; the result channel moving one result per cycle
// while rsp_stall is low sets the sustained rate. An accepted item passes
// through the queue and the current-entry register to the output register.
// Reset is synchronous: it clears the count, the halted flag, the queue and
// the output register and restores limit_enable to 0 and byte_limit to 65535.
// req_stall rises only when the queue is full; rsp_stall holds the output
// register and backs work up into the queue.
// ----------------------------------------------------------------------------
module utf8_encoder_with_byte_budget #(
   parameter int LEN_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [30:0]                      req_code_point,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [utf8e_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                             rsp_is_length,
   output logic [utf8e_pkg::TLEN_W-1:0]     rsp_total_length,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [utf8e_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [utf8e_pkg::TLEN_W-1:0]     csr_data
);

   // Configuration register indexes.
   localparam logic [utf8e_pkg::CSR_IDX_W-1:0] CSR_LIMIT_ENABLE = 2'd0;
   localparam logic [utf8e_pkg::CSR_IDX_W-1:0] CSR_BYTE_LIMIT   = 2'd1;
   localparam logic [utf8e_pkg::TLEN_W-1:0]    BYTE_LIMIT_RESET = 16'hFFFF;

   logic                          limit_enable_ff, limit_enable_in;
   logic [utf8e_pkg::TLEN_W-1:0]  byte_limit_ff, byte_limit_in;

   logic                 push;
   utf8e_pkg::entry_type push_data;
   logic                 pop;
   utf8e_pkg::entry_type head;
   logic                 full;
   logic                 empty;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_comb begin
      limit_enable_in = limit_enable_ff;
      byte_limit_in   = byte_limit_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_LIMIT_ENABLE) begin
            limit_enable_in = csr_data[0];
         end else if (csr_index == CSR_BYTE_LIMIT) begin
            byte_limit_in = csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_enable_ff <= 1'b0;
         byte_limit_ff   <= BYTE_LIMIT_RESET;
      end else begin
         limit_enable_ff <= limit_enable_in;
         byte_limit_ff   <= byte_limit_in;
      end
   end

   // Input is held off only while the queue is full.
   assign req_stall = full;

   utf8e_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .limit_enable   (limit_enable_ff),
      .byte_limit     (byte_limit_ff),
      .push           (push),
      .push_data      (push_data)
   );

   utf8e_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   utf8e_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .empty            (empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_is_length    (rsp_is_length),
      .rsp_total_length (rsp_total_length),
      .rsp_last         (rsp_last)
   );

endmodule
